[design/deq_pkg.sv]
// deq_pkg: shared widths, operation codes, command kinds and the command
// record passed from the front end to the back end of the deque
// no dependencies
`default_nettype none

package deq_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int OCC_W   = 9;
    localparam int M_DATA_W = 24;

    // operation codes as they arrive on the input channel
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    // decoded command kind, unused codes fold into a no-op
    typedef enum logic [2:0] {
        K_PUSH_FRONT,
        K_PUSH_BACK,
        K_POP_FRONT,
        K_POP_BACK,
        K_SEARCH,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_FIN
    } back_state_t;

endpackage

`default_nettype wire

[design/deq_front.sv]
// deq_front: input beat acceptance, operation decode and a two-slot
// command queue feeding the back end
// depends on deq_pkg
`default_nettype none

module deq_front
    import deq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,
    input  wire logic [OP_W-1:0]    s_tuser,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  wire logic               cmd_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       dec_cmd;
    logic       push;
    logic       pop;

    // decode the operation code
    always_comb begin
        dec_cmd.value = s_tdata;
        unique case (s_tuser)
            OP_PUSH_FRONT: dec_cmd.kind = K_PUSH_FRONT;
            OP_PUSH_BACK:  dec_cmd.kind = K_PUSH_BACK;
            OP_POP_FRONT:  dec_cmd.kind = K_POP_FRONT;
            OP_POP_BACK:   dec_cmd.kind = K_POP_BACK;
            OP_SEARCH:     dec_cmd.kind = K_SEARCH;
            default:       dec_cmd.kind = K_NOP;
        endcase
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

`default_nettype wire

[design/deq_back.sv]
// deq_back: ring store, head and count registers, the search walk and the
// result register driving the output channel
// depends on deq_pkg
`default_nettype none

module deq_back
    import deq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cmd_valid,
    input  wire cmd_t                cmd,
    output logic                     cmd_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [VALUE_W-1:0] mem [CAPACITY];

    back_state_t        state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [PTR_W-1:0]   rd_addr_reg;
    logic [CNT_W-1:0]   cmp_idx_reg;
    logic               pend_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               fin_ok_reg;
    logic [POS_W-1:0]   fin_pos_reg;

    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_empty_reg;
    logic [OCC_W-1:0]   out_occ_reg;

    logic               out_free;
    logic               full;
    logic               is_empty;
    logic [PTR_W-1:0]   head_dec;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   rd_addr_inc;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail;
    logic               issue;
    logic               hit;
    logic               last;
    logic               scan_done;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               load;
    logic               res_ok;
    logic [POS_W-1:0]   res_pos;
    logic               scan_start;

    assign out_free = !out_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign head_dec    = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - PTR_W'(1);
    assign head_inc    = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + PTR_W'(1);
    assign rd_addr_inc = (rd_addr_reg == PTR_W'(CAPACITY - 1)) ? '0
                                                                : rd_addr_reg + PTR_W'(1);

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(CAPACITY)) ? PTR_W'(tail_sum - SUM_W'(CAPACITY))
                                                      : PTR_W'(tail_sum);

    // scan pipeline: address issued one cycle, data compared the next
    assign issue     = (rd_idx_reg < count_reg);
    assign hit       = pend_reg && (rd_data_reg == key_reg);
    assign last      = pend_reg && ((cmp_idx_reg + CNT_W'(1)) == count_reg);
    assign scan_done = hit || last;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (cmd_valid && out_free && cmd.kind == K_SEARCH && !is_empty) begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN: begin
                if (scan_done) begin
                    state_next = B_FIN;
                end
            end
            B_FIN: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = tail;
        head_next  = head_reg;
        count_next = count_reg;
        load       = 1'b0;
        res_ok     = 1'b0;
        res_pos    = '0;
        scan_start = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    load    = 1'b1;
                    unique case (cmd.kind)
                        K_PUSH_FRONT: begin
                            if (!full) begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + CNT_W'(1);
                                res_ok     = 1'b1;
                            end
                        end
                        K_PUSH_BACK: begin
                            if (!full) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                res_ok     = 1'b1;
                            end
                        end
                        K_POP_FRONT: begin
                            if (!is_empty) begin
                                head_next  = head_inc;
                                count_next = count_reg - CNT_W'(1);
                                res_ok     = 1'b1;
                            end
                        end
                        K_POP_BACK: begin
                            if (!is_empty) begin
                                count_next = count_reg - CNT_W'(1);
                                res_ok     = 1'b1;
                            end
                        end
                        K_SEARCH: begin
                            if (!is_empty) begin
                                load       = 1'b0;
                                scan_start = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_SCAN: begin
            end
            B_FIN: begin
                if (out_free) begin
                    load    = 1'b1;
                    res_ok  = fin_ok_reg;
                    res_pos = fin_pos_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (scan_start) begin
                pend_reg <= 1'b0;
            end else if (state_reg == B_SCAN) begin
                pend_reg <= issue;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // search walk registers
    always_ff @(posedge aclk) begin
        if (scan_start) begin
            key_reg     <= cmd.value;
            rd_idx_reg  <= '0;
            rd_addr_reg <= head_reg;
        end else if (state_reg == B_SCAN) begin
            cmp_idx_reg <= rd_idx_reg;
            if (issue) begin
                rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
                rd_addr_reg <= rd_addr_inc;
            end
            if (scan_done) begin
                fin_ok_reg  <= hit;
                fin_pos_reg <= hit ? POS_W'(cmp_idx_reg) : '0;
            end
        end
    end

    // ring store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cmd.value;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_ok_reg    <= res_ok;
            out_pos_reg   <= res_pos;
            out_empty_reg <= (count_next == '0);
            out_occ_reg   <= OCC_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - OCC_W - POS_W - 2){1'b0}},
                       out_occ_reg, out_empty_reg, out_pos_reg, out_ok_reg};

endmodule

`default_nettype wire

[design/deque_with_search.sv]
// deque_with_search: top level of the bounded double-ended queue with search
// depends on deq_pkg, deq_front and deq_back
//
//  channel  | direction | beat contents (lowest bit first)
//  ---------+-----------+----------------------------------------------------
//  s_       | in        | tdata: value[31:0]; tuser: op[2:0]
//  m_       | out       | tdata: ok, position[7:0], empty_res, occupancy[8:0]
//
// pushes, pops and unused op codes are carried out in the back end as they
// leave the two-slot command queue, with their result loaded into the result register
// a search uses the single read port of the ring store to walk the held
// entries from the front, one per cycle, and stops at the
// first match
// aresetn empties the queue (head and count to zero); store contents are kept
// a full result register stalls the back end while the front keeps taking beats
// until its queue fills
`default_nettype none

module deque_with_search
    import deq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,   // value[31:0]
    input  wire logic [OP_W-1:0]     s_tuser,   // op[2:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // ok, position[8:1], empty_res, occupancy[18:10]
);

    // decoded commands between front and back end
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // front end: takes input beats, decodes the op and queues commands
    deq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back end: ring store, pointers, search walk and result register
    deq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[verif/deq_reply_checker.sv]
// deq_reply_checker: watches the input and result channels of deque_with_search,
// keeps its own copy of the deque, predicts each result beat and compares it
// depends on deq_pkg
module deq_reply_checker
    import deq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,   // value[31:0]
    input  wire logic [OP_W-1:0]     s_tuser,   // op[2:0]
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,   // ok, position, empty_res, occupancy
    output int                       mismatches,
    output int                       outstanding
);

    localparam int REPORT_LIMIT = 10;
    localparam int POS_LSB      = 1;
    localparam int EMPTY_BIT    = POS_LSB + POS_W;
    localparam int OCC_LSB      = EMPTY_BIT + 1;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
        logic             empty_res;
        logic [OCC_W-1:0] occupancy;
    } reply_t;

    // front of the deque is index 0
    logic [VALUE_W-1:0] held_values[$];
    reply_t             expected_replies[$];

    function automatic reply_t apply_command(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
        reply_t r;
        r = '0;
        case (op)
            OP_PUSH_FRONT: begin
                if (held_values.size() < CAPACITY_DEF) begin
                    held_values.push_front(value);
                    r.ok = 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (held_values.size() < CAPACITY_DEF) begin
                    held_values.push_back(value);
                    r.ok = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (held_values.size() > 0) begin
                    void'(held_values.pop_front());
                    r.ok = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (held_values.size() > 0) begin
                    void'(held_values.pop_back());
                    r.ok = 1'b1;
                end
            end
            OP_SEARCH: begin
                // first match from the front wins
                for (int i = 0; i < held_values.size(); i++) begin
                    if (held_values[i] == value) begin
                        r.ok       = 1'b1;
                        r.position = POS_W'(i);
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        r.empty_res = (held_values.size() == 0);
        r.occupancy = OCC_W'(held_values.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t seen;
        reply_t want;
        if (!aresetn) begin
            held_values.delete();
            expected_replies.delete();
            mismatches = 0;
        end else begin
            // results first: a beat accepted at this edge cannot answer itself
            if (m_tvalid && m_tready) begin
                seen.ok        = m_tdata[0];
                seen.position  = m_tdata[POS_LSB +: POS_W];
                seen.empty_res = m_tdata[EMPTY_BIT];
                seen.occupancy = m_tdata[OCC_LSB +: OCC_W];
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat %h arrived with nothing expected",
                                 $realtime, m_tdata);
                end else begin
                    want = expected_replies.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $write("%0t: mismatch (expected/actual) ok %0d/%0d pos %0d/%0d ",
                                   $realtime, want.ok, seen.ok, want.position,
                                   seen.position);
                            $display("empty %0d/%0d occupancy %0d/%0d",
                                     want.empty_res, seen.empty_res,
                                     want.occupancy, seen.occupancy);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_command(s_tuser, s_tdata));
        end
        outstanding = expected_replies.size();
    end

endmodule

[verif/deque_with_search_tb.sv]
// deque_with_search_tb: drives command beats into deque_with_search and
// pulls result beats with random gaps and stalls, checking runs in deq_reply_checker
// depends on deq_pkg, deque_with_search and deq_reply_checker
module deque_with_search_tb;
    import deq_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int RECEIVER_HOLD  = 400;    // long result-side hold-off
    localparam int SETTLE_CYCLES  = 300;    // longer than a full-depth search
    localparam int WATCHDOG_LIMIT = 8000;   // cycles with no beat on either side
    localparam int POOL_SIZE      = 8;
    localparam int POOL_IDX_W     = $clog2(POOL_SIZE);

    // op codes with no operation behind them
    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_SEARCH + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

    localparam logic [VALUE_W-1:0] VALUE_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VALUE_ONES = 32'hffff_ffff;
    localparam logic [VALUE_W-1:0] MARKER     = 32'h1234_5678;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata  = '0;    // value[31:0]
    logic [OP_W-1:0]     s_tuser  = '0;    // op[2:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // ok, position[8:1], empty_res, occupancy[18:10]

    int mismatches;
    int outstanding;
    int hold_asked = 0;                     // long hold-offs requested of the result side

    // values reused often so that searches hit and duplicates appear
    logic [VALUE_W-1:0] value_pool[POOL_SIZE];

    initial begin
        forever #5 aclk = ~aclk;
    end

    deque_with_search #(
        .CAPACITY (CAPACITY_DEF)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    deq_reply_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // mostly short stalls, now and then a long one
    function automatic int stall_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 80);
        return $urandom_range(1, 4);
    endfunction

    // sender gap: often none at all so that back-to-back runs occur
    function automatic int sender_gap();
        if ($urandom_range(0, 9) < 7)
            return 0;
        return stall_length();
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
        return $urandom;
    endfunction

    // result side: ready bursts broken by stalls, plus a long hold-off on request
    initial begin : result_sink
        int hold_done;
        int burst;
        int gap;
        hold_done = 0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (burst) @(posedge aclk);
            if (hold_asked > hold_done) begin
                hold_done++;
                gap = RECEIVER_HOLD;
            end else begin
                gap = stall_length();
            end
            m_tready <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    end

    // ends the run if neither channel moves a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("deque_with_search verification failed");
        $finish;
    end

    // offer one beat and return at the edge where it is taken
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // sender stops until every predicted result beat has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // random commands with a given mix, the rest go to unused op codes
    task automatic run_phase(input int items, input int push_pct, input int pop_pct,
                             input int search_pct);
        int roll;
        logic [OP_W-1:0] op;
        logic [VALUE_W-1:0] value;
        for (int n = 0; n < items; n++) begin
            idle_sender(sender_gap());
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                op    = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                value = pick_value(40);
            end else if (roll < push_pct + pop_pct) begin
                op    = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                value = $urandom;
            end else if (roll < push_pct + pop_pct + search_pct) begin
                op    = OP_SEARCH;
                value = pick_value(75);
            end else begin
                op    = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                value = $urandom;
            end
            send_beat(op, value);
        end
    endtask

    initial begin : stimulus
        value_pool[0] = VALUE_MIN;
        value_pool[1] = VALUE_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
            value_pool[POOL_IDX_W'(i)] = $urandom;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        idle_sender(2);

        // directed: empty-queue failures and ignored op codes
        send_beat(OP_POP_FRONT, VALUE_ONES);
        send_beat(OP_POP_BACK, '0);
        send_beat(OP_SEARCH, '0);
        for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
            send_beat(OP_W'(c), $urandom);

        // directed: field extremes at both ends, then searches hit and miss
        send_beat(OP_PUSH_BACK, VALUE_MAX);
        send_beat(OP_PUSH_FRONT, VALUE_MIN);
        send_beat(OP_PUSH_BACK, VALUE_ONES);
        send_beat(OP_PUSH_FRONT, '0);
        send_beat(OP_PUSH_BACK, VALUE_ONES);
        send_beat(OP_SEARCH, VALUE_ONES);       // first of two equal entries
        send_beat(OP_SEARCH, VALUE_MIN);
        send_beat(OP_SEARCH, VALUE_MAX);
        send_beat(OP_SEARCH, '0);               // match at the front
        send_beat(OP_SEARCH, 32'h0000_0001);    // no match
        send_beat(OP_POP_FRONT, '0);
        send_beat(OP_POP_BACK, '0);
        send_beat(OP_POP_FRONT, '0);
        send_beat(OP_POP_BACK, '0);
        send_beat(OP_POP_FRONT, '0);            // removes the only entry
        send_beat(OP_POP_BACK, '0);
        send_beat(OP_SEARCH, VALUE_MAX);
        wait_drained();

        // fill to capacity while the result side holds off, so the input stalls
        hold_asked++;
        run_phase(320, 92, 3, 4);
        wait_drained();

        // full queue: refresh the back slot and search the deepest position
        send_beat(OP_PUSH_FRONT, $urandom);     // refused when full
        send_beat(OP_POP_BACK, '0);
        send_beat(OP_PUSH_BACK, MARKER);
        send_beat(OP_SEARCH, MARKER);
        send_beat(OP_SEARCH, ~MARKER);          // walks every held entry
        wait_drained();

        // drain past empty
        run_phase(320, 3, 92, 4);
        wait_drained();

        // balanced traffic around low occupancy, another long hold-off
        hold_asked++;
        run_phase(350, 35, 30, 30);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("deque_with_search verification clean");
        else
            $display("deque_with_search verification failed");
        $finish;
    end

endmodule

[sim.f]
design/deq_pkg.sv
design/deq_front.sv
design/deq_back.sv
design/deque_with_search.sv
verif/deq_reply_checker.sv
verif/deque_with_search_tb.sv
